/* design/effective_address_unit_assert.svh */
// Assertion macros for the effective address unit.
// Needs clk and arst_n in the scope of each use; empty under SYNTHESIS.
`ifndef EFFECTIVE_ADDRESS_UNIT_ASSERT_SVH
`define EFFECTIVE_ADDRESS_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define EAU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("effective address unit: same-cycle check failed");
`define EAU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("effective address unit: next-cycle check failed");
`else
`define EAU_ASSERT_NOW(lbl, ante, cons)
`define EAU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/eau_pkg.sv */
// Shared types, codes and constants of the effective address unit.
// No dependencies; imported by effective_address_unit, eau_calc and the bench.
package eau_pkg;

	localparam int unsigned DATA_W       = 32;
	localparam int unsigned RF_DEPTH     = 16;
	localparam int unsigned RF_IDX_W     = 4;
	localparam int unsigned ADDR_OUT_W   = 24;
	localparam int unsigned ADDRESS_BITS_DEF = 24;
	localparam int unsigned IDX_LONG_BIT = 11;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_EA   = 1'b1
	} eau_action_t;

	typedef enum logic [1:0] {
		SIZE_BYTE = 2'd0,
		SIZE_WORD = 2'd1,
		SIZE_LONG = 2'd2
	} eau_size_t;

	typedef enum logic [2:0] {
		MODE_DREG    = 3'd0,
		MODE_AREG    = 3'd1,
		MODE_IND     = 3'd2,
		MODE_POSTINC = 3'd3,
		MODE_PREDEC  = 3'd4,
		MODE_DISP    = 3'd5,
		MODE_INDEX   = 3'd6,
		MODE_SPECIAL = 3'd7
	} eau_mode_t;

	localparam logic [2:0] REG_ABS_WORD = 3'd0;
	localparam logic [2:0] REG_ABS_LONG = 3'd1;
	localparam logic [2:0] REG_SP       = 3'd7;

	typedef struct packed {
		logic                action;
		logic [RF_IDX_W-1:0] load_index;
		logic [31:0]         load_value;
		logic [1:0]          op_size;
		logic [2:0]          ea_mode;
		logic [2:0]          ea_register;
		logic [15:0]         ext_word;
		logic [31:0]         ext_long;
	} eau_req_t;

	typedef struct packed {
		logic [ADDR_OUT_W-1:0] address;
		logic                  is_register;
		logic [RF_IDX_W-1:0]   operand_register;
		logic [31:0]           register_operand;
		logic                  illegal;
		logic [1:0]            ext_words_used;
	} eau_rsp_t;

	typedef struct packed {
		logic                we;
		logic [RF_IDX_W-1:0] idx;
		logic [DATA_W-1:0]   data;
	} eau_wb_t;

endpackage

/* design/effective_address_unit.sv */
// Top level of the 68000 effective address unit: register file, pipeline, output register.
// Depends on eau_pkg, eau_ram, eau_calc and effective_address_unit_assert.svh.
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (eau_req_t)
//   result  | rsp_valid | rsp_stall | rsp (eau_rsp_t), compute requests only
//
// One request per cycle while req_stall is low. A result passes the register file read,
// then compute and output register. Loads and address updates write back in the compute
// stage; the newest write is forwarded to a read that missed it.
// Reset clears the per-entry valid bits so every entry reads zero; no clearing pass.
// rsp_stall on a full output register holds a compute request in its stage and raises
// req_stall in the same cycle; a load never waits for the output.
`include "effective_address_unit_assert.svh"
module effective_address_unit import eau_pkg::*; #(
	parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  eau_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output eau_rsp_t rsp
);

	logic                accept;
	logic                out_free;
	logic                move_s1;
	logic [RF_IDX_W-1:0] raddr_a;
	logic [RF_IDX_W-1:0] raddr_b;
	logic [DATA_W-1:0]   rdata_a;
	logic [DATA_W-1:0]   rdata_b;
	logic [DATA_W-1:0]   base_val;
	logic [DATA_W-1:0]   index_val;
	eau_rsp_t            calc_rsp;
	eau_wb_t             calc_wb;
	logic                we;

	logic                valid_s1;
	eau_req_t            req_s1;
	logic [RF_IDX_W-1:0] addr_a_s1;
	logic [RF_IDX_W-1:0] addr_b_s1;
	logic                va_s1;
	logic                vb_s1;

	logic [RF_DEPTH-1:0] vbit_q;
	logic                fwd_valid_q;
	logic [RF_IDX_W-1:0] fwd_idx_q;
	logic [DATA_W-1:0]   fwd_data_q;

	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid || !rsp_stall;
	assign move_s1   = valid_s1 && ((req_s1.action == ACT_LOAD) || out_free);
	assign req_stall = valid_s1 && !move_s1;
	assign we        = move_s1 && calc_wb.we;

	assign raddr_a = (eau_mode_t'(req.ea_mode) == MODE_DREG) ? {1'b0, req.ea_register}
		: {1'b1, req.ea_register};
	assign raddr_b = req.ext_word[15:12];

	eau_ram #(.WIDTH(DATA_W), .DEPTH(RF_DEPTH)) u_rf_a (
		.clk   (clk),
		.we    (we),
		.waddr (calc_wb.idx),
		.wdata (calc_wb.data),
		.re    (accept),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	eau_ram #(.WIDTH(DATA_W), .DEPTH(RF_DEPTH)) u_rf_b (
		.clk   (clk),
		.we    (we),
		.waddr (calc_wb.idx),
		.wdata (calc_wb.data),
		.re    (accept),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	// Forward the newest write; fall back to zero for never-written entries.
	assign base_val = (fwd_valid_q && fwd_idx_q == addr_a_s1) ? fwd_data_q
		: (va_s1 ? rdata_a : '0);
	assign index_val = (fwd_valid_q && fwd_idx_q == addr_b_s1) ? fwd_data_q
		: (vb_s1 ? rdata_b : '0);

	eau_calc #(.ADDRESS_BITS(ADDRESS_BITS)) u_calc (
		.req       (req_s1),
		.base_val  (base_val),
		.index_val (index_val),
		.rsp       (calc_rsp),
		.wb        (calc_wb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1    <= req;
			addr_a_s1 <= raddr_a;
			addr_b_s1 <= raddr_b;
			va_s1     <= vbit_q[raddr_a];
			vb_s1     <= vbit_q[raddr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbit_q      <= '0;
			fwd_valid_q <= 1'b0;
		end else if (we) begin
			vbit_q[calc_wb.idx] <= 1'b1;
			fwd_valid_q         <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			fwd_idx_q  <= calc_wb.idx;
			fwd_data_q <= calc_wb.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (move_s1 && req_s1.action == ACT_EA) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && req_s1.action == ACT_EA) begin
			rsp <= calc_rsp;
		end
	end

	`EAU_ASSERT_NOW(a_stall_only_when_busy, req_stall, valid_s1)
	`EAU_ASSERT_NEXT(a_held_stage_stays, valid_s1 && !move_s1, valid_s1)
	`EAU_ASSERT_NOW(a_no_write_on_illegal, valid_s1 && req_s1.action == ACT_EA && calc_rsp.illegal, !calc_wb.we)
	`EAU_ASSERT_NOW(a_register_result_no_address, rsp_valid && (rsp.is_register || rsp.illegal), rsp.address == '0)

endmodule

/* design/eau_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module eau_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/eau_calc.sv */
// Address, operand and register write-back computation for one request.
// Depends on eau_pkg.
module eau_calc import eau_pkg::*; #(
	parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF
) (
	input  eau_req_t          req,
	input  logic [DATA_W-1:0] base_val,
	input  logic [DATA_W-1:0] index_val,
	output eau_rsp_t          rsp,
	output eau_wb_t           wb
);

	localparam logic [31:0] AddrMask = 32'((64'd1 << ADDRESS_BITS) - 64'd1);

	logic [2:0]        step;
	logic [31:0]       size_mask;
	logic [31:0]       addr;
	logic [31:0]       ix;
	logic [31:0]       opval;
	logic [3:0]        opreg;
	logic              is_reg;
	logic              ill;
	logic [1:0]        used;
	logic [3:0]        a_idx;
	logic [31:0]       masked;

	assign a_idx = {1'b1, req.ea_register};

	always_comb begin
		unique case (req.op_size)
			SIZE_BYTE: begin
				step      = (req.ea_register == REG_SP) ? 3'd2 : 3'd1;
				size_mask = 32'h0000_00FF;
			end
			SIZE_WORD: begin
				step      = 3'd2;
				size_mask = 32'h0000_FFFF;
			end
			default: begin
				step      = 3'd4;
				size_mask = 32'hFFFF_FFFF;
			end
		endcase
	end

	assign ix = req.ext_word[IDX_LONG_BIT] ? index_val
		: {{16{index_val[15]}}, index_val[15:0]};

	always_comb begin
		addr   = '0;
		is_reg = 1'b0;
		opreg  = '0;
		opval  = '0;
		ill    = 1'b0;
		used   = 2'd0;
		wb     = '0;
		unique case (eau_mode_t'(req.ea_mode))
			MODE_DREG: begin
				is_reg = 1'b1;
				opreg  = {1'b0, req.ea_register};
				opval  = base_val & size_mask;
			end
			MODE_AREG: begin
				if (req.op_size == SIZE_BYTE) begin
					ill = 1'b1;
				end else begin
					is_reg = 1'b1;
					opreg  = a_idx;
					opval  = base_val & size_mask;
				end
			end
			MODE_IND: begin
				addr = base_val;
			end
			MODE_POSTINC: begin
				addr    = base_val;
				wb.we   = 1'b1;
				wb.idx  = a_idx;
				wb.data = base_val + {29'd0, step};
			end
			MODE_PREDEC: begin
				addr    = base_val - {29'd0, step};
				wb.we   = 1'b1;
				wb.idx  = a_idx;
				wb.data = base_val - {29'd0, step};
			end
			MODE_DISP: begin
				addr = base_val + {{16{req.ext_word[15]}}, req.ext_word};
				used = 2'd1;
			end
			MODE_INDEX: begin
				addr = ix + base_val + {{24{req.ext_word[7]}}, req.ext_word[7:0]};
				used = 2'd1;
			end
			MODE_SPECIAL: begin
				priority if (req.ea_register == REG_ABS_WORD) begin
					addr = {{16{req.ext_word[15]}}, req.ext_word};
					used = 2'd1;
				end else if (req.ea_register == REG_ABS_LONG) begin
					addr = req.ext_long;
					used = 2'd2;
				end else begin
					ill = 1'b1;
				end
			end
		endcase
		if (req.action == ACT_LOAD) begin
			wb.we   = 1'b1;
			wb.idx  = req.load_index;
			wb.data = req.load_value;
		end
	end

	assign masked = (ill || is_reg) ? 32'd0 : (addr & AddrMask);

	always_comb begin
		rsp.address          = masked[ADDR_OUT_W-1:0];
		rsp.is_register      = is_reg;
		rsp.operand_register = opreg;
		rsp.register_operand = opval;
		rsp.illegal          = ill;
		rsp.ext_words_used   = used;
	end

endmodule

/* bench/tb_effective_address_unit.sv */
// Self-checking bench for effective_address_unit: a directed table, then random requests,
// each compute result checked against a pinned value or a register-file predictor kept alongside the block.
// Depends on eau_pkg and the effective_address_unit RTL only.
module tb_effective_address_unit import eau_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_REQUESTS = 1625;
	localparam int unsigned CALM_REQUESTS   = 150;
	localparam int unsigned LATENCY         = 2;
	localparam int unsigned WATCHDOG_LIMIT  = 1000;
	localparam logic [31:0] EA_MASK = 32'((64'd1 << ADDRESS_BITS_DEF) - 64'd1);

	typedef struct {
		eau_req_t rq;
		bit       pinned;
		eau_rsp_t rs;
	} ea_row_t;

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_stall;
	eau_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_stall = 1'b0;
	eau_rsp_t rsp;

	logic [31:0] shadow_rf [RF_DEPTH] = '{default: '0};
	eau_rsp_t    awaited_ea [$];
	ea_row_t     directed_rows [$];
	int unsigned mismatch_count = 0;
	bit          calm = 1'b0;

	effective_address_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic eau_req_t ea_req(logic [1:0] size, eau_mode_t mode, logic [2:0] regno,
			logic [15:0] ext = '0, logic [31:0] extl = '0);
		eau_req_t r;
		r = '0;
		r.action      = ACT_EA;
		r.op_size     = size;
		r.ea_mode     = mode;
		r.ea_register = regno;
		r.ext_word    = ext;
		r.ext_long    = extl;
		return r;
	endfunction

	function automatic eau_req_t load_req(logic [3:0] idx, logic [31:0] value);
		eau_req_t r;
		r = '0;
		r.action     = ACT_LOAD;
		r.load_index = idx;
		r.load_value = value;
		return r;
	endfunction

	function automatic eau_rsp_t rsp_of(logic [23:0] addr, logic isreg, logic [3:0] opreg,
			logic [31:0] value, logic ill, logic [1:0] used);
		eau_rsp_t s;
		s.address          = addr;
		s.is_register      = isreg;
		s.operand_register = opreg;
		s.register_operand = value;
		s.illegal          = ill;
		s.ext_words_used   = used;
		return s;
	endfunction

	// Resolve one request against the shadow register file, updating it as the block would.
	function automatic eau_rsp_t resolve_ea(eau_req_t r);
		eau_rsp_t    res;
		logic [3:0]  areg_idx;
		logic [31:0] ea;
		logic [31:0] stride;
		logic [31:0] size_mask;
		logic [31:0] ix;
		res      = '0;
		ea       = '0;
		areg_idx = {1'b1, r.ea_register};
		if (r.op_size == SIZE_BYTE) begin
			stride    = (r.ea_register == REG_SP) ? 32'd2 : 32'd1;
			size_mask = 32'h0000_00FF;
		end else if (r.op_size == SIZE_WORD) begin
			stride    = 32'd2;
			size_mask = 32'h0000_FFFF;
		end else begin
			stride    = 32'd4;
			size_mask = 32'hFFFF_FFFF;
		end
		if (r.action == ACT_LOAD) begin
			shadow_rf[r.load_index] = r.load_value;
			return res;
		end
		case (eau_mode_t'(r.ea_mode))
			MODE_DREG: begin
				res.is_register      = 1'b1;
				res.operand_register = {1'b0, r.ea_register};
				res.register_operand = shadow_rf[{1'b0, r.ea_register}] & size_mask;
			end
			MODE_AREG: begin
				if (r.op_size == SIZE_BYTE) begin
					res.illegal = 1'b1;
				end else begin
					res.is_register      = 1'b1;
					res.operand_register = areg_idx;
					res.register_operand = shadow_rf[areg_idx] & size_mask;
				end
			end
			MODE_IND: ea = shadow_rf[areg_idx];
			MODE_POSTINC: begin
				ea = shadow_rf[areg_idx];
				shadow_rf[areg_idx] = ea + stride;
			end
			MODE_PREDEC: begin
				shadow_rf[areg_idx] = shadow_rf[areg_idx] - stride;
				ea = shadow_rf[areg_idx];
			end
			MODE_DISP: begin
				ea = shadow_rf[areg_idx] + {{16{r.ext_word[15]}}, r.ext_word};
				res.ext_words_used = 2'd1;
			end
			MODE_INDEX: begin
				ix = shadow_rf[r.ext_word[15:12]];
				if (!r.ext_word[IDX_LONG_BIT])
					ix = {{16{ix[15]}}, ix[15:0]};
				ea = ix + shadow_rf[areg_idx] + {{24{r.ext_word[7]}}, r.ext_word[7:0]};
				res.ext_words_used = 2'd1;
			end
			default: begin
				if (r.ea_register == REG_ABS_WORD) begin
					ea = {{16{r.ext_word[15]}}, r.ext_word};
					res.ext_words_used = 2'd1;
				end else if (r.ea_register == REG_ABS_LONG) begin
					ea = r.ext_long;
					res.ext_words_used = 2'd2;
				end else begin
					res.illegal = 1'b1;
				end
			end
		endcase
		ea          = ea & EA_MASK;
		res.address = ea[ADDR_OUT_W-1:0];
		return res;
	endfunction

	function automatic eau_req_t random_request();
		eau_req_t r;
		r.action     = ($urandom_range(0, 3) != 0) ? ACT_EA : ACT_LOAD;
		r.load_index = 4'($urandom_range(0, 15));
		case ($urandom_range(0, 3))
			0: r.load_value = $urandom;
			1: r.load_value = $urandom_range(0, 64);
			2: r.load_value = 32'hFFFF_FFFF - $urandom_range(0, 64);
			default: r.load_value = 32'h0100_0000 + $urandom_range(0, 64) - 32'd32;
		endcase
		r.op_size     = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		r.ea_mode     = 3'($urandom_range(0, 7));
		r.ea_register = 3'($urandom_range(0, 7));
		if (r.ea_mode == MODE_SPECIAL && $urandom_range(0, 3) != 0)
			r.ea_register = 3'($urandom_range(0, 1));
		r.ext_word = 16'($urandom);
		r.ext_long = $urandom;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
	endtask

	task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	task automatic send_request(eau_req_t r, bit pinned, eau_rsp_t typed);
		eau_rsp_t forecast;
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		forecast = resolve_ea(r);
		if (r.action == ACT_EA)
			awaited_ea.push_back(pinned ? typed : forecast);
	endtask

	// Hold the sender until every result in flight has come back.
	task automatic drain_results();
		req_valid <= 1'b0;
		do @(posedge clk); while (awaited_ea.size() != 0);
	endtask

	always @(posedge clk) begin
		eau_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_ea.size() == 0) begin
				report_mismatch("unexpected result", 32'(rsp.address), 32'd0);
			end else begin
				want = awaited_ea.pop_front();
				check_field("address", 32'(rsp.address), 32'(want.address));
				check_field("is_register", 32'(rsp.is_register),
					32'(want.is_register));
				check_field("operand_register", 32'(rsp.operand_register),
					32'(want.operand_register));
				check_field("register_operand", rsp.register_operand,
					want.register_operand);
				check_field("illegal", 32'(rsp.illegal), 32'(want.illegal));
				check_field("ext_words_used", 32'(rsp.ext_words_used),
					32'(want.ext_words_used));
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 6) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		int unsigned i;
		directed_rows.push_back('{ea_req(SIZE_LONG, MODE_DREG, 3'd0), 1'b1,
			rsp_of(24'h0, 1'b1, 4'd0, 32'h0, 1'b0, 2'd0)});
		directed_rows.push_back('{ea_req(SIZE_BYTE, MODE_AREG, 3'd3), 1'b1,
			rsp_of(24'h0, 1'b0, 4'd0, 32'h0, 1'b1, 2'd0)});
		directed_rows.push_back('{ea_req(SIZE_WORD, MODE_SPECIAL, 3'd2), 1'b1,
			rsp_of(24'h0, 1'b0, 4'd0, 32'h0, 1'b1, 2'd0)});
		directed_rows.push_back('{ea_req(2'd3, MODE_SPECIAL, 3'd7), 1'b1,
			rsp_of(24'h0, 1'b0, 4'd0, 32'h0, 1'b1, 2'd0)});
		directed_rows.push_back('{ea_req(SIZE_LONG, MODE_SPECIAL, REG_ABS_WORD, 16'h8000), 1'b1,
			rsp_of(24'hFF8000, 1'b0, 4'd0, 32'h0, 1'b0, 2'd1)});
		directed_rows.push_back('{ea_req(SIZE_BYTE, MODE_SPECIAL, REG_ABS_LONG, 16'h0,
			32'hFFFF_FFFF), 1'b1, rsp_of(24'hFFFFFF, 1'b0, 4'd0, 32'h0, 1'b0, 2'd2)});
		directed_rows.push_back('{ea_req(SIZE_WORD, MODE_SPECIAL, REG_ABS_WORD, 16'h7FFF), 1'b1,
			rsp_of(24'h007FFF, 1'b0, 4'd0, 32'h0, 1'b0, 2'd1)});
		directed_rows.push_back('{ea_req(SIZE_LONG, MODE_PREDEC, 3'd0), 1'b0, '0});
		directed_rows.push_back('{load_req(4'd0, 32'hFFFF_FFFF), 1'b0, '0});
		directed_rows.push_back('{load_req(4'd15, 32'h0000_1001), 1'b0, '0});
		directed_rows.push_back('{load_req(4'd8, 32'hFFFF_FFFF), 1'b0, '0});
		directed_rows.push_back('{load_req(4'd7, 32'h0000_8000), 1'b0, '0});
		directed_rows.push_back('{ea_req(SIZE_BYTE, MODE_DREG, 3'd0), 1'b1,
			rsp_of(24'h0, 1'b1, 4'd0, 32'h0000_00FF, 1'b0, 2'd0)});
		directed_rows.push_back('{ea_req(SIZE_WORD, MODE_DREG, 3'd7), 1'b0, '0});
		directed_rows.push_back('{ea_req(SIZE_WORD, MODE_AREG, 3'd0), 1'b0, '0});
		directed_rows.push_back('{ea_req(2'd3, MODE_AREG, REG_SP), 1'b0, '0});
		directed_rows.push_back('{ea_req(SIZE_BYTE, MODE_IND, REG_SP), 1'b0, '0});
		directed_rows.push_back('{ea_req(SIZE_BYTE, MODE_POSTINC, REG_SP), 1'b0, '0});
		directed_rows.push_back('{ea_req(SIZE_BYTE, MODE_PREDEC, REG_SP), 1'b0, '0});
		directed_rows.push_back('{ea_req(SIZE_LONG, MODE_POSTINC, 3'd0), 1'b0, '0});
		directed_rows.push_back('{ea_req(SIZE_BYTE, MODE_POSTINC, 3'd3), 1'b0, '0});
		directed_rows.push_back('{ea_req(SIZE_WORD, MODE_DISP, REG_SP, 16'h8000), 1'b0, '0});
		directed_rows.push_back('{ea_req(SIZE_LONG, MODE_INDEX, 3'd0, 16'h7080), 1'b0, '0});
		directed_rows.push_back('{ea_req(SIZE_LONG, MODE_INDEX, REG_SP, 16'hF8FF), 1'b0, '0});
		directed_rows.push_back('{ea_req(SIZE_WORD, MODE_DISP, 3'd0, 16'h7FFF), 1'b0, '0});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			send_request(directed_rows[k].rq, directed_rows[k].pinned, directed_rows[k].rs);
		drain_results();

		for (i = 0; i < RANDOM_REQUESTS; i++) begin
			calm = (i >= RANDOM_REQUESTS - CALM_REQUESTS);
			if (i == RANDOM_REQUESTS / 2) begin
				drain_results();
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			send_request(random_request(), 1'b0, '0);
		end
		drain_results();
		repeat (LATENCY + 6) @(posedge clk);
		if (awaited_ea.size() != 0)
			report_mismatch("missing results", 32'(awaited_ea.size()), 32'd0);

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
